/* hw/rtl/pmu_pkg.sv */
// pmu_pkg: shared constants, types and helper functions of the palette renderer
// used by every file of the block but pmu_ram, depends on nothing
package pmu_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int MAX_DIM       = 1024;
  localparam int MAX_SCALE     = 8;

  localparam int PAL_AW = $clog2(PALETTE_DEPTH);
  localparam int CNT_W  = $clog2(MAX_DIM);
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int S_W    = $clog2(MAX_SCALE + 1);
  localparam int SUB_W  = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
  localparam int SC_W   = S_W + CNT_W;
  localparam int WS_W   = DIM_W + S_W;

  // fixed field widths
  localparam int IDX_W     = 26;
  localparam int ID_W      = 32;
  localparam int CHAN_W    = 8;
  localparam int RGB_W     = 24;
  localparam int EIDX_W    = 8;
  localparam int CFG_DIM_W = 11;
  localparam int CFG_S_W   = 4;
  localparam int CFG_DW    = 11;
  localparam int CFG_IDX_W = 2;

  localparam logic [CHAN_W-1:0] DARKEN    = 8'd40;
  localparam logic [EIDX_W-1:0] WRAP_MASK = 8'h7f;

  // job queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // commands
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_RENDER = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FLIP   = 2'd3;

  // register reset values
  localparam logic [CFG_DIM_W-1:0] RST_WIDTH  = 11'd256;
  localparam logic [CFG_DIM_W-1:0] RST_HEIGHT = 11'd256;
  localparam logic [CFG_S_W-1:0]   RST_SCALE  = 4'd1;
  localparam logic                 RST_FLIP   = 1'b0;

  // effective geometry after clamping
  typedef struct packed {
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [S_W-1:0]   s;
    logic             flip;
  } dims_t;

  // one classified id waiting for the back end
  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              inv;
    logic              last_id;
    logic [SC_W-1:0]   sc;
    logic [SC_W-1:0]   sv;
  } job_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (int'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

  function automatic logic [S_W-1:0] clamp_scale(input logic [CFG_S_W-1:0] v);
    logic [S_W-1:0] r;
    if (v == '0) begin
      r = S_W'(1);
    end else if (int'(v) > MAX_SCALE) begin
      r = S_W'(MAX_SCALE);
    end else begin
      r = S_W'(v);
    end
    return r;
  endfunction

  function automatic logic [CHAN_W-1:0] darken(input logic [CHAN_W-1:0] c);
    return (c > DARKEN) ? (c - DARKEN) : '0;
  endfunction

endpackage

/* hw/rtl/pmu_ram.sv */
// pmu_ram: generic single write port ram with registered read
// no dependencies
module pmu_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/pmu_front.sv */
// pmu_front: input side, palette writes, raster counters and id classification
// depends on pmu_pkg and pmu_ram
module pmu_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic                        in_cmd,
  input  logic signed [pmu_pkg::ID_W-1:0] in_class_id,
  input  logic [pmu_pkg::EIDX_W-1:0]  in_entry_index,
  input  logic [pmu_pkg::RGB_W-1:0]   in_entry_rgb,
  input  pmu_pkg::dims_t              dims,
  input  logic [pmu_pkg::Q_CW-1:0]    q_level,
  output logic                        job_push,
  output pmu_pkg::job_t               job
);

  logic                            accept;
  logic                            is_render;
  logic                            wrap;
  logic [pmu_pkg::CNT_W-1:0]       ecol;
  logic [pmu_pkg::CNT_W-1:0]       erow;
  logic                            new_frame;
  logic                            bad;
  logic [pmu_pkg::EIDX_W-1:0]      rd_idx;
  logic                            rd_in;
  logic                            wr_en;
  logic                            col_end;
  logic                            row_end;
  logic [pmu_pkg::CNT_W-1:0]       vrow;
  logic [pmu_pkg::SC_W-1:0]        sc;
  logic [pmu_pkg::SC_W-1:0]        sv;
  logic [pmu_pkg::RGB_W-1:0]       rdata;
  logic [pmu_pkg::RGB_W-1:0]       rgb;
  logic [pmu_pkg::CHAN_W-1:0]      r_raw, g_raw, b_raw;

  logic [pmu_pkg::CNT_W-1:0]       col_r, col_nxt;
  logic [pmu_pkg::CNT_W-1:0]       row_r, row_nxt;
  logic                            flag_r, flag_nxt;
  logic                            vld_r [pmu_pkg::PALETTE_DEPTH];

  logic                            s1_v_r;
  logic                            s1_bad_r;
  logic                            s1_hit_r;
  logic                            s1_inv_r;
  logic                            s1_last_r;
  logic [pmu_pkg::SC_W-1:0]        s1_sc_r;
  logic [pmu_pkg::SC_W-1:0]        s1_sv_r;

  // room is reserved for the item in the read stage
  assign in_full   = (int'(q_level) + int'(s1_v_r)) >= pmu_pkg::Q_DEPTH;
  assign accept    = in_push && !in_full;
  assign is_render = (in_cmd == pmu_pkg::CMD_RENDER);

  // counters left out of range by a register change restart the frame
  assign wrap      = (pmu_pkg::DIM_W'(col_r) >= dims.w) || (pmu_pkg::DIM_W'(row_r) >= dims.h);
  assign ecol      = wrap ? '0 : col_r;
  assign erow      = wrap ? '0 : row_r;
  assign new_frame = (ecol == '0) && (erow == '0);

  assign bad    = |in_class_id[pmu_pkg::ID_W-1:pmu_pkg::EIDX_W];
  assign rd_idx = bad ? (in_class_id[pmu_pkg::EIDX_W-1:0] & pmu_pkg::WRAP_MASK)
                      : in_class_id[pmu_pkg::EIDX_W-1:0];
  assign rd_in  = int'(rd_idx) < pmu_pkg::PALETTE_DEPTH;
  assign wr_en  = accept && !is_render && (int'(in_entry_index) < pmu_pkg::PALETTE_DEPTH);

  assign col_end = (pmu_pkg::DIM_W'(ecol) + pmu_pkg::DIM_W'(1)) == dims.w;
  assign row_end = (pmu_pkg::DIM_W'(erow) + pmu_pkg::DIM_W'(1)) == dims.h;
  assign vrow    = dims.flip ? erow
                             : pmu_pkg::CNT_W'(dims.h - pmu_pkg::DIM_W'(1) - pmu_pkg::DIM_W'(erow));
  assign sc      = pmu_pkg::SC_W'(dims.s) * pmu_pkg::SC_W'(ecol);
  assign sv      = pmu_pkg::SC_W'(dims.s) * pmu_pkg::SC_W'(vrow);

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    flag_nxt = flag_r;
    if (accept && is_render) begin
      flag_nxt = bad || (flag_r && !new_frame);
      if (col_end) begin
        col_nxt = '0;
        row_nxt = row_end ? '0 : (erow + pmu_pkg::CNT_W'(1));
      end else begin
        col_nxt = ecol + pmu_pkg::CNT_W'(1);
        row_nxt = erow;
      end
    end
  end

  pmu_ram #(
    .WIDTH(pmu_pkg::RGB_W),
    .DEPTH(pmu_pkg::PALETTE_DEPTH)
  ) u_palette (
    .clk  (clk),
    .we   (wr_en),
    .waddr(in_entry_index[pmu_pkg::PAL_AW-1:0]),
    .wdata(in_entry_rgb),
    .raddr(rd_idx[pmu_pkg::PAL_AW-1:0]),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      flag_r <= 1'b0;
      s1_v_r <= 1'b0;
      for (int i = 0; i < pmu_pkg::PALETTE_DEPTH; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      flag_r <= flag_nxt;
      s1_v_r <= accept && is_render;
      if (wr_en) begin
        vld_r[in_entry_index[pmu_pkg::PAL_AW-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_render) begin
      s1_bad_r  <= bad;
      s1_hit_r  <= rd_in && vld_r[rd_idx[pmu_pkg::PAL_AW-1:0]];
      s1_inv_r  <= flag_nxt;
      s1_last_r <= col_end && row_end;
      s1_sc_r   <= sc;
      s1_sv_r   <= sv;
    end
  end

  // entries never written read as zero
  assign rgb   = s1_hit_r ? rdata : '0;
  assign r_raw = rgb[23:16];
  assign g_raw = rgb[15:8];
  assign b_raw = rgb[7:0];

  assign job_push    = s1_v_r;
  assign job.red     = s1_bad_r ? pmu_pkg::darken(r_raw) : r_raw;
  assign job.green   = s1_bad_r ? pmu_pkg::darken(g_raw) : g_raw;
  assign job.blue    = s1_bad_r ? pmu_pkg::darken(b_raw) : b_raw;
  assign job.inv     = s1_inv_r;
  assign job.last_id = s1_last_r;
  assign job.sc      = s1_sc_r;
  assign job.sv      = s1_sv_r;

endmodule

/* hw/rtl/pmu_queue.sv */
// pmu_queue: short job queue between front and back
// depends on pmu_pkg
module pmu_queue (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  pmu_pkg::job_t            din,
  input  logic                     pop,
  output pmu_pkg::job_t            dout,
  output logic                     nempty,
  output logic [pmu_pkg::Q_CW-1:0] level
);

  pmu_pkg::job_t               mem_r [pmu_pkg::Q_DEPTH];
  logic [pmu_pkg::Q_AW-1:0]    wr_r, rd_r;
  logic [pmu_pkg::Q_CW-1:0]    cnt_r, cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + pmu_pkg::Q_CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - pmu_pkg::Q_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_r <= (int'(wr_r) == pmu_pkg::Q_DEPTH - 1) ? '0 : wr_r + pmu_pkg::Q_AW'(1);
      end
      if (pop) begin
        rd_r <= (int'(rd_r) == pmu_pkg::Q_DEPTH - 1) ? '0 : rd_r + pmu_pkg::Q_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= din;
    end
  end

  assign dout   = mem_r[rd_r];
  assign nempty = (cnt_r != '0);
  assign level  = cnt_r;

endmodule

/* hw/rtl/pmu_back.sv */
// pmu_back: expands each job into scale by scale pixels and holds the result register
// depends on pmu_pkg
module pmu_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pmu_pkg::dims_t              dims,
  input  logic                        q_nempty,
  input  pmu_pkg::job_t               q_head,
  output logic                        q_pop,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [pmu_pkg::IDX_W-1:0]   out_pixel_index,
  output logic [pmu_pkg::CHAN_W-1:0]  out_red,
  output logic [pmu_pkg::CHAN_W-1:0]  out_green,
  output logic [pmu_pkg::CHAN_W-1:0]  out_blue,
  output logic                        out_last_of_run,
  output logic                        out_frame_done,
  output logic                        out_invalid_seen
);

  logic [pmu_pkg::WS_W-1:0]          ws_r;
  logic [pmu_pkg::WS_W+pmu_pkg::SC_W-1:0] prod;
  logic [pmu_pkg::SUB_W-1:0]         s_m1;
  logic                              emit, emit_last, row_last, load, out_take;

  logic                              busy_r, busy_nxt;
  logic [pmu_pkg::SUB_W-1:0]         m_r, n_r;
  logic [pmu_pkg::IDX_W-1:0]         base_r;
  pmu_pkg::job_t                     cur_r;

  logic                              ov_r;
  logic [pmu_pkg::IDX_W-1:0]         o_idx_r;
  logic [pmu_pkg::CHAN_W-1:0]        o_red_r, o_green_r, o_blue_r;
  logic                              o_last_r, o_done_r, o_inv_r;

  assign out_take  = out_pop && ov_r;
  assign s_m1      = pmu_pkg::SUB_W'(dims.s - pmu_pkg::S_W'(1));
  assign emit      = busy_r && (!ov_r || out_take);
  assign row_last  = (n_r == s_m1);
  assign emit_last = emit && row_last && (m_r == s_m1);
  // next job loads alongside the last pixel of the current one
  assign load      = q_nempty && (!busy_r || emit_last);
  assign q_pop     = load;
  assign prod      = ws_r * q_head.sv;

  always_comb begin
    busy_nxt = busy_r;
    if (load) begin
      busy_nxt = 1'b1;
    end else if (emit_last) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      if (emit) begin
        ov_r <= 1'b1;
      end else if (out_take) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ws_r <= pmu_pkg::WS_W'(dims.w) * pmu_pkg::WS_W'(dims.s);
    if (load) begin
      cur_r  <= q_head;
      m_r    <= '0;
      n_r    <= '0;
      base_r <= pmu_pkg::IDX_W'(q_head.sc) + pmu_pkg::IDX_W'(prod);
    end else if (emit) begin
      if (row_last) begin
        n_r    <= '0;
        m_r    <= m_r + pmu_pkg::SUB_W'(1);
        base_r <= base_r + pmu_pkg::IDX_W'(ws_r);
      end else begin
        n_r <= n_r + pmu_pkg::SUB_W'(1);
      end
    end
    if (emit) begin
      o_idx_r   <= base_r + pmu_pkg::IDX_W'(n_r);
      o_red_r   <= cur_r.red;
      o_green_r <= cur_r.green;
      o_blue_r  <= cur_r.blue;
      o_last_r  <= row_last && (m_r == s_m1);
      o_done_r  <= row_last && (m_r == s_m1) && cur_r.last_id;
      o_inv_r   <= cur_r.inv;
    end
  end

  assign out_empty        = !ov_r;
  assign out_pixel_index  = o_idx_r;
  assign out_red          = o_red_r;
  assign out_green        = o_green_r;
  assign out_blue         = o_blue_r;
  assign out_last_of_run  = o_last_r;
  assign out_frame_done   = o_done_r;
  assign out_invalid_seen = o_inv_r;

endmodule

/* hw/rtl/palette_map_upscale_renderer.sv */
// palette_map_upscale_renderer: top level, configuration registers and the three parts
// depends on pmu_pkg, pmu_front, pmu_queue and pmu_back
//
// turns a raster of class ids into rgb pixels. an input beat with cmd 0 loads one
// 24-bit palette entry and gives no output; a beat with cmd 1 renders the next id in
// raster order and gives scale*scale output beats, sub-row by sub-row, left to right,
// each with its linear pixel index in an image width*scale pixels wide. rows are
// stored bottom-up unless flip is set. ids outside 0..255 take palette[id & 0x7f]
// darkened by 40 per channel and raise invalid_seen until the next frame starts.
// the palette sits in a ram with one valid bit per entry, so it reads as zero right
// after reset with no clearing pass. the back end emits one pixel per cycle while
// the output is not stalled and loads the next id alongside the last pixel of the
// current one, so at scale 1 one id per cycle is sustained. an id passes the read
// stage registers, the job queue and the back end's job register before its first
// pixel is registered at the output. a four-deep job queue lets the input keep going
// while the back end or the output stalls. the user must write registers only while
// the block is idle; the block itself does not enforce this. width and height of 0
// act as 1 and above 1024 as 1024, scale of 0 acts as 1 and above 8 as 8
module palette_map_upscale_renderer (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_we,
  input  logic [pmu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pmu_pkg::CFG_DW-1:0]     cfg_data,
  // input queue side
  input  logic                           in_push,
  output logic                           in_full,
  input  logic                           in_cmd,
  input  logic signed [pmu_pkg::ID_W-1:0] in_class_id,
  input  logic [pmu_pkg::EIDX_W-1:0]     in_entry_index,
  input  logic [pmu_pkg::RGB_W-1:0]      in_entry_rgb,
  // result queue side
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [pmu_pkg::IDX_W-1:0]      out_pixel_index,
  output logic [pmu_pkg::CHAN_W-1:0]     out_red,
  output logic [pmu_pkg::CHAN_W-1:0]     out_green,
  output logic [pmu_pkg::CHAN_W-1:0]     out_blue,
  output logic                           out_last_of_run,
  output logic                           out_frame_done,
  output logic                           out_invalid_seen
);

  logic [pmu_pkg::CFG_DIM_W-1:0] width_r;
  logic [pmu_pkg::CFG_DIM_W-1:0] height_r;
  logic [pmu_pkg::CFG_S_W-1:0]   scale_r;
  logic                          flip_r;

  pmu_pkg::dims_t                dims;
  pmu_pkg::job_t                 job, q_head;
  logic                          job_push, q_pop, q_nempty;
  logic [pmu_pkg::Q_CW-1:0]      q_level;

  // register writes, no read-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= pmu_pkg::RST_WIDTH;
      height_r <= pmu_pkg::RST_HEIGHT;
      scale_r  <= pmu_pkg::RST_SCALE;
      flip_r   <= pmu_pkg::RST_FLIP;
    end else if (cfg_we) begin
      case (cfg_index)
        pmu_pkg::REG_WIDTH: begin
          width_r <= cfg_data[pmu_pkg::CFG_DIM_W-1:0];
        end
        pmu_pkg::REG_HEIGHT: begin
          height_r <= cfg_data[pmu_pkg::CFG_DIM_W-1:0];
        end
        pmu_pkg::REG_SCALE: begin
          scale_r <= cfg_data[pmu_pkg::CFG_S_W-1:0];
        end
        pmu_pkg::REG_FLIP: begin
          flip_r <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  // effective geometry, clamped into the supported range
  assign dims.w    = pmu_pkg::clamp_dim(width_r);
  assign dims.h    = pmu_pkg::clamp_dim(height_r);
  assign dims.s    = pmu_pkg::clamp_scale(scale_r);
  assign dims.flip = flip_r;

  // front: palette writes, raster counters, palette read and darkening
  pmu_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_cmd        (in_cmd),
    .in_class_id   (in_class_id),
    .in_entry_index(in_entry_index),
    .in_entry_rgb  (in_entry_rgb),
    .dims          (dims),
    .q_level       (q_level),
    .job_push      (job_push),
    .job           (job)
  );

  // classified ids waiting for expansion
  pmu_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .din   (job),
    .pop   (q_pop),
    .dout  (q_head),
    .nempty(q_nempty),
    .level (q_level)
  );

  // back: pixel expansion and the result register
  pmu_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .dims            (dims),
    .q_nempty        (q_nempty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_pixel_index (out_pixel_index),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_last_of_run (out_last_of_run),
    .out_frame_done  (out_frame_done),
    .out_invalid_seen(out_invalid_seen)
  );

endmodule
